/* rtl/core/pva_pkg.sv */
// ----------------------------------------------------------------------------
// pva_pkg
// Shared constants, types and helpers of the priority voice allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package pva_pkg;

  localparam int VOICES     = 32;
  localparam int BUSES      = 8;
  localparam int VOICE_W    = 5;
  localparam int BUS_W      = 3;
  localparam int PRIO_W     = 8;
  localparam int VOL_W      = 16;
  localparam int SND_W      = 16;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  localparam logic [VOL_W-1:0] UNITY    = 16'd8192;
  localparam logic [VOL_W-1:0] GAIN_MAX = 16'd32768;

  localparam logic [1:0] FN_PLAY    = 2'd0;
  localparam logic [1:0] FN_FINISH  = 2'd1;
  localparam logic [1:0] FN_STOPALL = 2'd2;
  localparam logic [1:0] FN_SETVOL  = 2'd3;

  localparam logic [1:0] ACT_START  = 2'd0;
  localparam logic [1:0] ACT_STOP   = 2'd1;
  localparam logic [1:0] ACT_GAIN   = 2'd2;
  localparam logic [1:0] ACT_REJECT = 2'd3;

  typedef enum logic [2:0] {
    K_NOP,
    K_PLAY,
    K_REJECT,
    K_FINISH,
    K_STOPALL,
    K_SETVOL
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [PRIO_W-1:0]   prio;
    logic [BUS_W-1:0]    bus;
    logic [VOL_W-1:0]    vol;
    logic [VOICE_W-1:0]  slot;
    logic [SND_W-1:0]    snd;
  } cmd_t;

  typedef struct packed {
    logic [1:0]          action;
    logic [VOICE_W-1:0]  voice;
    logic [VOL_W-1:0]    gain;
    logic [SND_W-1:0]    sound;
  } res_t;

  function automatic logic bus_in_range(input logic [BUS_W-1:0] b);
    return {1'b0, b} < (BUS_W+1)'(BUSES);
  endfunction

  function automatic logic slot_in_range(input logic [VOICE_W-1:0] s);
    return {1'b0, s} < (VOICE_W+1)'(VOICES);
  endfunction

  function automatic logic [VOL_W-1:0] vol_clamp(input logic [VOL_W-1:0] v);
    return (v > GAIN_MAX) ? GAIN_MAX : v;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/pva_front.sv */
// ----------------------------------------------------------------------------
// pva_front
// Accepts command words, classifies them and queues the ones with work.
// ----------------------------------------------------------------------------
`default_nettype none

module pva_front (
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [1:0]                  in_func,
  input  wire logic [pva_pkg::PRIO_W-1:0]  in_priority_req,
  input  wire logic [pva_pkg::BUS_W-1:0]   in_bus,
  input  wire logic [pva_pkg::VOL_W-1:0]   in_volume,
  input  wire logic [pva_pkg::VOICE_W-1:0] in_slot,
  input  wire logic [pva_pkg::SND_W-1:0]   in_sound_handle,
  output logic                             push_valid,
  input  wire logic                        push_ready,
  output pva_pkg::cmd_t                    push_cmd
);

  pva_pkg::kind_t kind;

  always_comb begin
    unique case (in_func)
      pva_pkg::FN_PLAY: begin
        kind = (in_priority_req == '0) ? pva_pkg::K_REJECT : pva_pkg::K_PLAY;
      end
      pva_pkg::FN_FINISH: begin
        kind = pva_pkg::slot_in_range(in_slot) ? pva_pkg::K_FINISH : pva_pkg::K_NOP;
      end
      pva_pkg::FN_STOPALL: begin
        kind = pva_pkg::K_STOPALL;
      end
      pva_pkg::FN_SETVOL: begin
        kind = pva_pkg::bus_in_range(in_bus) ? pva_pkg::K_SETVOL : pva_pkg::K_NOP;
      end
      default: begin
        kind = pva_pkg::K_NOP;
      end
    endcase
  end

  // ignored words are taken without queueing
  assign in_ready        = push_ready;
  assign push_valid      = in_valid && (kind != pva_pkg::K_NOP);
  assign push_cmd.kind   = kind;
  assign push_cmd.prio   = in_priority_req;
  assign push_cmd.bus    = in_bus;
  assign push_cmd.vol    = in_volume;
  assign push_cmd.slot   = in_slot;
  assign push_cmd.snd    = in_sound_handle;

endmodule

`default_nettype wire

/* rtl/core/pva_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// pva_cmd_fifo
// Short command queue between the front end and the voice engine.
// ----------------------------------------------------------------------------
`default_nettype none

module pva_cmd_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push_valid,
  output logic               push_ready,
  input  wire pva_pkg::cmd_t push_cmd,
  output logic               pop_valid,
  input  wire logic          pop,
  output pva_pkg::cmd_t      pop_cmd
);

  pva_pkg::cmd_t                 mem_r [pva_pkg::FIFO_DEPTH];
  logic [pva_pkg::FIFO_AW-1:0]   wr_ptr_r;
  logic [pva_pkg::FIFO_AW-1:0]   rd_ptr_r;
  logic [pva_pkg::FIFO_AW:0]     cnt_r;
  logic                          do_push;
  logic                          do_pop;

  assign push_ready = cnt_r != (pva_pkg::FIFO_AW+1)'(pva_pkg::FIFO_DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_cmd    = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        mem_r[wr_ptr_r] <= push_cmd;
        wr_ptr_r        <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!do_push && do_pop) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/pva_engine.sv */
// ----------------------------------------------------------------------------
// pva_engine
// Voice slot table, slot scan, gain multiply and result output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pva_engine (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cmd_valid,
  output logic               cmd_pop,
  input  wire pva_pkg::cmd_t cmd_in,
  output logic               out_valid,
  input  wire logic          out_ready,
  output pva_pkg::res_t      out_res,
  output logic               out_last
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_STEAL,
    S_ALLOC,
    S_MUL1,
    S_MUL2,
    S_GAIN,
    S_START,
    S_SWEEP,
    S_REJ,
    S_FLUSH
  } state_t;

  localparam int P1_W = 2 * pva_pkg::VOL_W;
  localparam int P2_W = 3 * pva_pkg::VOL_W;
  localparam int SH   = 26;

  state_t                          state_r;
  pva_pkg::cmd_t                   cmd_r;
  logic [pva_pkg::VOICE_W-1:0]     ptr_r;
  logic [pva_pkg::PRIO_W-1:0]      low_r;
  logic [pva_pkg::VOICE_W-1:0]     low_idx_r;
  logic [P1_W-1:0]                 p1_r;
  logic [P2_W-1:0]                 p2_r;
  pva_pkg::res_t                   hold_r;
  logic                            hold_v_r;
  pva_pkg::res_t                   out_res_r;
  logic                            out_last_r;
  logic                            out_valid_r;

  logic [pva_pkg::PRIO_W-1:0]      slot_prio_r [pva_pkg::VOICES];
  logic [pva_pkg::BUS_W-1:0]       slot_bus_r  [pva_pkg::VOICES];
  logic [pva_pkg::VOL_W-1:0]       slot_vol_r  [pva_pkg::VOICES];
  logic [pva_pkg::VOL_W-1:0]       bus_vol_r   [pva_pkg::BUSES];

  logic [pva_pkg::PRIO_W-1:0]      cur_prio;
  logic [pva_pkg::BUS_W-1:0]       cur_bus;
  logic [pva_pkg::VOL_W-1:0]       cur_vol;
  logic                            last_ptr;
  logic                            lt;
  logic [pva_pkg::PRIO_W-1:0]      low_nxt;
  logic [pva_pkg::VOICE_W-1:0]     low_idx_nxt;
  logic [pva_pkg::VOL_W-1:0]       bv_sel;
  logic [P2_W-SH-1:0]              gain_sh;
  logic [pva_pkg::VOL_W-1:0]       gain_val;
  logic                            gain_match;
  logic                            can_emit;
  logic                            push_ok;
  logic                            push_en;
  logic                            flush_en;
  pva_pkg::res_t                   push_res;
  logic [pva_pkg::VOICE_W-1:0]     ptr_inc;

  assign cur_prio    = slot_prio_r[ptr_r];
  assign cur_bus     = slot_bus_r[ptr_r];
  assign cur_vol     = slot_vol_r[ptr_r];
  assign last_ptr    = ptr_r == pva_pkg::VOICE_W'(pva_pkg::VOICES - 1);
  assign ptr_inc     = ptr_r + 1'b1;
  assign lt          = cur_prio < low_r;
  assign low_nxt     = lt ? cur_prio : low_r;
  assign low_idx_nxt = lt ? ptr_r : low_idx_r;
  assign bv_sel      = (cur_bus == '0) ? pva_pkg::UNITY : bus_vol_r[cur_bus];
  assign gain_sh     = p2_r[P2_W-1:SH];
  assign gain_val    = (gain_sh > (P2_W-SH)'(pva_pkg::GAIN_MAX)) ? pva_pkg::GAIN_MAX
                                                              : gain_sh[pva_pkg::VOL_W-1:0];
  assign gain_match  = pva_pkg::bus_in_range(cur_bus) &&
                       ((cmd_r.bus == '0) || ((cur_bus == cmd_r.bus) && (cur_prio != '0)));

  assign can_emit = !out_valid_r || out_ready;
  assign push_ok  = !hold_v_r || can_emit;
  assign flush_en = (state_r == S_FLUSH) && hold_v_r && can_emit;
  assign cmd_pop  = (state_r == S_IDLE) && cmd_valid;

  // a held result goes out with last set only when the command ends
  always_comb begin
    push_en  = 1'b0;
    push_res = '0;
    unique case (state_r)
      S_STEAL: begin
        push_en         = push_ok;
        push_res.action = pva_pkg::ACT_STOP;
        push_res.voice  = ptr_r;
      end
      S_GAIN: begin
        push_en         = push_ok;
        push_res.action = pva_pkg::ACT_GAIN;
        push_res.voice  = ptr_r;
        push_res.gain   = gain_val;
      end
      S_START: begin
        push_en         = push_ok;
        push_res.action = pva_pkg::ACT_START;
        push_res.voice  = ptr_r;
        push_res.sound  = cmd_r.snd;
      end
      S_REJ: begin
        push_en         = push_ok;
        push_res.action = pva_pkg::ACT_REJECT;
      end
      S_SWEEP: begin
        if ((cmd_r.kind == pva_pkg::K_STOPALL) && (cur_prio != '0)) begin
          push_en         = push_ok;
          push_res.action = pva_pkg::ACT_STOP;
          push_res.voice  = ptr_r;
        end
      end
      default: begin
        push_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < pva_pkg::VOICES; i++) begin
        slot_prio_r[i] <= '0;
        slot_bus_r[i]  <= '0;
        slot_vol_r[i]  <= '0;
      end
      for (int b = 0; b < pva_pkg::BUSES; b++) begin
        bus_vol_r[b] <= pva_pkg::UNITY;
      end
    end else begin
      if ((push_en && hold_v_r) || flush_en) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (push_en) begin
        if (hold_v_r) begin
          out_res_r  <= hold_r;
          out_last_r <= 1'b0;
        end
        hold_r   <= push_res;
        hold_v_r <= 1'b1;
      end
      if (flush_en) begin
        out_res_r  <= hold_r;
        out_last_r <= 1'b1;
        hold_v_r   <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (cmd_valid) begin
            cmd_r     <= cmd_in;
            ptr_r     <= '0;
            low_r     <= '1;
            low_idx_r <= '0;
            case (cmd_in.kind)
              pva_pkg::K_PLAY:    state_r <= S_SCAN;
              pva_pkg::K_REJECT:  state_r <= S_REJ;
              pva_pkg::K_FINISH:  slot_prio_r[cmd_in.slot] <= '0;
              pva_pkg::K_STOPALL: state_r <= S_SWEEP;
              pva_pkg::K_SETVOL: begin
                bus_vol_r[cmd_in.bus] <= pva_pkg::vol_clamp(cmd_in.vol);
                state_r               <= S_SWEEP;
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_SCAN: begin
          if (cur_prio == '0) begin
            state_r <= S_ALLOC;
          end else begin
            low_r     <= low_nxt;
            low_idx_r <= low_idx_nxt;
            if (last_ptr) begin
              if (cmd_r.prio > low_nxt) begin
                ptr_r   <= low_idx_nxt;
                state_r <= S_STEAL;
              end else begin
                state_r <= S_REJ;
              end
            end else begin
              ptr_r <= ptr_inc;
            end
          end
        end
        S_STEAL: begin
          if (push_ok) begin
            state_r <= S_ALLOC;
          end
        end
        S_ALLOC: begin
          slot_prio_r[ptr_r] <= cmd_r.prio;
          slot_bus_r[ptr_r]  <= cmd_r.bus;
          slot_vol_r[ptr_r]  <= cmd_r.vol;
          state_r <= pva_pkg::bus_in_range(cmd_r.bus) ? S_MUL1 : S_START;
        end
        S_MUL1: begin
          p1_r    <= P1_W'(bus_vol_r[0]) * P1_W'(bv_sel);
          state_r <= S_MUL2;
        end
        S_MUL2: begin
          p2_r    <= P2_W'(p1_r) * P2_W'(cur_vol);
          state_r <= S_GAIN;
        end
        S_GAIN: begin
          if (push_ok) begin
            if (cmd_r.kind == pva_pkg::K_PLAY) begin
              state_r <= S_START;
            end else if (last_ptr) begin
              state_r <= S_FLUSH;
            end else begin
              ptr_r   <= ptr_inc;
              state_r <= S_SWEEP;
            end
          end
        end
        S_START: begin
          if (push_ok) begin
            state_r <= S_FLUSH;
          end
        end
        S_REJ: begin
          if (push_ok) begin
            state_r <= S_FLUSH;
          end
        end
        S_SWEEP: begin
          if (cmd_r.kind == pva_pkg::K_STOPALL) begin
            if (cur_prio != '0) begin
              if (push_ok) begin
                slot_prio_r[ptr_r] <= '0;
                if (last_ptr) begin
                  state_r <= S_FLUSH;
                end else begin
                  ptr_r <= ptr_inc;
                end
              end
            end else if (last_ptr) begin
              state_r <= S_FLUSH;
            end else begin
              ptr_r <= ptr_inc;
            end
          end else begin
            if (gain_match) begin
              state_r <= S_MUL1;
            end else if (last_ptr) begin
              state_r <= S_FLUSH;
            end else begin
              ptr_r <= ptr_inc;
            end
          end
        end
        S_FLUSH: begin
          if (!hold_v_r || can_emit) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign out_last  = out_last_r;

endmodule

`default_nettype wire

/* rtl/core/priority_voice_allocator_top.sv */
// ----------------------------------------------------------------------------
// priority_voice_allocator_top
// Voice slot allocator with priority stealing and bus gain updates.
//
// Input channel (in_*): one command word per valid/ready handshake. The front
// end classifies it and queues it in a four-deep command queue; finished
// events on out-of-range slots and volume writes to out-of-range buses are
// taken and dropped there.
// Output channel (out_*): zero or more result words per command, last set on
// the final one. Results leave through an output register behind a one-word
// hold stage; the engine waits on a receiver stall only once both are full.
// Command flow: the engine runs one command at a time. A play, once popped,
// scans the slot table one slot per cycle, then runs steal (when no slot is
// free), allocate, the two-stage gain multiply, start and final flush.
// Stop-all walks every slot and stops each busy one, holding on a receiver
// stall; a bus volume write walks the slots and gives a gain result for each
// matching one (every slot for the master bus). A finished event frees its
// slot without leaving the idle state.
// Reset: all slots free, slot buses and volumes zero, bus volumes 1.0; the
// queue and output register empty. No clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_voice_allocator_top (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [1:0]                  in_func,
  input  wire logic [pva_pkg::PRIO_W-1:0]  in_priority_req,
  input  wire logic [pva_pkg::BUS_W-1:0]   in_bus,
  input  wire logic [pva_pkg::VOL_W-1:0]   in_volume,
  input  wire logic [pva_pkg::VOICE_W-1:0] in_slot,
  input  wire logic [pva_pkg::SND_W-1:0]   in_sound_handle,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [1:0]                       out_action,
  output logic [pva_pkg::VOICE_W-1:0]      out_voice,
  output logic [pva_pkg::VOL_W-1:0]        out_gain,
  output logic [pva_pkg::SND_W-1:0]        out_sound_out,
  output logic                             out_last
);

  logic           push_valid;
  logic           push_ready;
  pva_pkg::cmd_t  push_cmd;
  logic           pop_valid;
  logic           pop;
  pva_pkg::cmd_t  pop_cmd;
  pva_pkg::res_t  res;

  pva_front u_front (
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_priority_req (in_priority_req),
    .in_bus          (in_bus),
    .in_volume       (in_volume),
    .in_slot         (in_slot),
    .in_sound_handle (in_sound_handle),
    .push_valid      (push_valid),
    .push_ready      (push_ready),
    .push_cmd        (push_cmd)
  );

  pva_cmd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_cmd    (pop_cmd)
  );

  pva_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (pop_valid),
    .cmd_pop   (pop),
    .cmd_in    (pop_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res),
    .out_last  (out_last)
  );

  assign out_action    = res.action;
  assign out_voice     = res.voice;
  assign out_gain      = res.gain;
  assign out_sound_out = res.sound;

endmodule

`default_nettype wire

/* bench/priority_voice_allocator_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_voice_allocator_top_tb
// Drives play, finished, stop-all and bus volume commands into the voice
// allocator with random gaps on both channels. A scoreboard keeps its own
// copy of the slot table and bus volumes, predicts the start, stop, gain and
// reject words of every command, and checks each output word in order.
// ----------------------------------------------------------------------------

module priority_voice_allocator_top_tb;

  typedef struct packed {
    logic [1:0]                  action;
    logic [pva_pkg::VOICE_W-1:0] voice;
    logic [pva_pkg::VOL_W-1:0]   gain;
    logic [pva_pkg::SND_W-1:0]   sound;
    logic                        last;
  } action_word_t;

  class voice_alloc_model;
    logic [pva_pkg::PRIO_W-1:0] prio_tab[pva_pkg::VOICES];
    logic [pva_pkg::BUS_W-1:0]  bus_tab[pva_pkg::VOICES];
    logic [pva_pkg::VOL_W-1:0]  vol_tab[pva_pkg::VOICES];
    logic [pva_pkg::VOL_W-1:0]  bus_level[pva_pkg::BUSES];
    action_word_t               pending_actions[$];
    int                         mismatches;

    function new();
      for (int i = 0; i < pva_pkg::VOICES; i++) begin
        prio_tab[i] = '0;
        bus_tab[i]  = '0;
        vol_tab[i]  = '0;
      end
      for (int i = 0; i < pva_pkg::BUSES; i++) begin
        bus_level[i] = pva_pkg::UNITY;
      end
      mismatches = 0;
    endfunction

    function void push_action(logic [1:0] act, int voice, logic [pva_pkg::VOL_W-1:0] gain,
                              logic [pva_pkg::SND_W-1:0] sound);
      action_word_t w;
      w.action = act;
      w.voice  = pva_pkg::VOICE_W'(voice);
      w.gain   = gain;
      w.sound  = sound;
      w.last   = 1'b0;
      pending_actions = {pending_actions, w};
    endfunction

    function void push_gain(int i);
      logic [47:0]               prod;
      logic [pva_pkg::VOL_W-1:0] bv;
      if (int'(bus_tab[i]) >= pva_pkg::BUSES) return;
      bv = (bus_tab[i] == '0) ? pva_pkg::UNITY : bus_level[bus_tab[i]];
      prod = {32'd0, bus_level[0]} * {32'd0, bv} * {32'd0, vol_tab[i]};
      prod = prod >> 26;
      if (prod > {32'd0, pva_pkg::GAIN_MAX}) prod = {32'd0, pva_pkg::GAIN_MAX};
      push_action(pva_pkg::ACT_GAIN, i, prod[pva_pkg::VOL_W-1:0], '0);
    endfunction

    function void take_command(logic [1:0] func, logic [pva_pkg::PRIO_W-1:0] prio,
                               logic [pva_pkg::BUS_W-1:0] bus,
                               logic [pva_pkg::VOL_W-1:0] vol,
                               logic [pva_pkg::VOICE_W-1:0] slot,
                               logic [pva_pkg::SND_W-1:0] snd);
      int           first;
      bit           found;
      int           idx;
      int           low_idx;
      int           low;
      action_word_t w;
      first = pending_actions.size();
      if (func == pva_pkg::FN_PLAY) begin
        if (prio == '0) begin
          push_action(pva_pkg::ACT_REJECT, 0, '0, '0);
        end else begin
          found   = 1'b0;
          idx     = 0;
          low_idx = 0;
          low     = 1 << 30;
          for (int i = 0; i < pva_pkg::VOICES; i++) begin
            if (!found) begin
              if (prio_tab[i] == '0) begin
                found = 1'b1;
                idx   = i;
              end else if (int'(prio_tab[i]) < low) begin
                low     = int'(prio_tab[i]);
                low_idx = i;
              end
            end
          end
          if (!found && int'(prio) > low) begin
            found = 1'b1;
            idx   = low_idx;
            push_action(pva_pkg::ACT_STOP, idx, '0, '0);
          end
          if (!found) begin
            push_action(pva_pkg::ACT_REJECT, 0, '0, '0);
          end else begin
            prio_tab[idx] = prio;
            bus_tab[idx]  = bus;
            vol_tab[idx]  = vol;
            push_gain(idx);
            push_action(pva_pkg::ACT_START, idx, '0, snd);
          end
        end
      end else if (func == pva_pkg::FN_FINISH) begin
        if (int'(slot) < pva_pkg::VOICES) prio_tab[slot] = '0;
      end else if (func == pva_pkg::FN_STOPALL) begin
        for (int i = 0; i < pva_pkg::VOICES; i++) begin
          if (prio_tab[i] != '0) begin
            push_action(pva_pkg::ACT_STOP, i, '0, '0);
            prio_tab[i] = '0;
          end
        end
      end else begin
        if (int'(bus) < pva_pkg::BUSES) begin
          bus_level[bus] = (vol > pva_pkg::GAIN_MAX) ? pva_pkg::GAIN_MAX : vol;
          for (int i = 0; i < pva_pkg::VOICES; i++) begin
            if (bus == '0 || (bus_tab[i] == bus && prio_tab[i] != '0)) push_gain(i);
          end
        end
      end
      if (pending_actions.size() > first) begin
        w = pending_actions[pending_actions.size() - 1];
        w.last = 1'b1;
        pending_actions[pending_actions.size() - 1] = w;
      end
    endfunction

    task report(string what, action_word_t got, action_word_t want);
      mismatches++;
      $display("[%0t] %s: got act=%0d voice=%0d gain=%0d snd=%0d last=%0b, ",
               $realtime, what, got.action, got.voice, got.gain, got.sound, got.last,
               "want act=%0d voice=%0d gain=%0d snd=%0d last=%0b",
               want.action, want.voice, want.gain, want.sound, want.last);
    endtask

    task match_action(action_word_t got);
      action_word_t want;
      if (pending_actions.size() == 0) begin
        report("unexpected word", got, got);
      end else begin
        want = pending_actions.pop_front();
        if (got.action !== want.action || got.voice !== want.voice ||
            got.gain !== want.gain || got.sound !== want.sound ||
            got.last !== want.last)
          report("word mismatch", got, want);
      end
    endtask
  endclass

  localparam int STALL_LIMIT = 4000;
  localparam int RANDOM_ITEMS = 430;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [1:0]                  in_func = pva_pkg::FN_PLAY;
  logic [pva_pkg::PRIO_W-1:0]  in_priority_req = '0;
  logic [pva_pkg::BUS_W-1:0]   in_bus = '0;
  logic [pva_pkg::VOL_W-1:0]   in_volume = '0;
  logic [pva_pkg::VOICE_W-1:0] in_slot = '0;
  logic [pva_pkg::SND_W-1:0]   in_sound_handle = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [1:0]                  out_action;
  logic [pva_pkg::VOICE_W-1:0] out_voice;
  logic [pva_pkg::VOL_W-1:0]   out_gain;
  logic [pva_pkg::SND_W-1:0]   out_sound_out;
  logic                        out_last;

  logic               calm = 1'b0;
  int                 quiet_cycles = 0;

  voice_alloc_model model = new();

  priority_voice_allocator_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_func(in_func),
    .in_priority_req(in_priority_req),
    .in_bus(in_bus),
    .in_volume(in_volume),
    .in_slot(in_slot),
    .in_sound_handle(in_sound_handle),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_action(out_action),
    .out_voice(out_voice),
    .out_gain(out_gain),
    .out_sound_out(out_sound_out),
    .out_last(out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) out_ready <= calm || ($urandom_range(99) >= 26);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready)
        model.match_action({out_action, out_voice, out_gain, out_sound_out, out_last});
      if (in_valid && in_ready)
        model.take_command(in_func, in_priority_req, in_bus, in_volume, in_slot,
                           in_sound_handle);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic send_command(logic [1:0] func, logic [pva_pkg::PRIO_W-1:0] prio,
                              logic [pva_pkg::BUS_W-1:0] bus,
                              logic [pva_pkg::VOL_W-1:0] vol,
                              logic [pva_pkg::VOICE_W-1:0] slot,
                              logic [pva_pkg::SND_W-1:0] snd);
    while (!calm && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_func         <= func;
    in_priority_req <= prio;
    in_bus          <= bus;
    in_volume       <= vol;
    in_slot         <= slot;
    in_sound_handle <= snd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic [pva_pkg::VOL_W-1:0] pick_volume();
    case ($urandom_range(9))
      0: pick_volume = '0;
      1: pick_volume = pva_pkg::UNITY;
      2: pick_volume = pva_pkg::GAIN_MAX;
      3: pick_volume = pva_pkg::GAIN_MAX + 16'd1;
      4: pick_volume = '1;
      default: pick_volume = pva_pkg::VOL_W'($urandom);
    endcase
  endfunction

  function automatic logic [pva_pkg::PRIO_W-1:0] pick_priority();
    int r;
    r = $urandom_range(15);
    if (r == 0) pick_priority = '0;
    else if (r < 9) pick_priority = pva_pkg::PRIO_W'($urandom_range(6, 1));
    else pick_priority = pva_pkg::PRIO_W'($urandom_range(255, 1));
  endfunction

  initial begin
    logic [1:0] func;
    int         r;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners
    send_command(pva_pkg::FN_PLAY, 8'd0, 3'd2, 16'd4096, 5'd0, 16'h1234);
    send_command(pva_pkg::FN_PLAY, 8'd255, 3'd0, 16'hFFFF, 5'd31, 16'hFFFF);
    send_command(pva_pkg::FN_PLAY, 8'd1, 3'd7, 16'd0, 5'd0, 16'h0000);
    send_command(pva_pkg::FN_PLAY, 8'd128, 3'd5, 16'd12345, 5'd17, 16'hA5A5);
    send_command(pva_pkg::FN_SETVOL, 8'd0, 3'd7, 16'hFFFF, 5'd0, 16'd0);
    send_command(pva_pkg::FN_SETVOL, 8'd0, 3'd5, 16'd32769, 5'd0, 16'd0);
    send_command(pva_pkg::FN_SETVOL, 8'd0, 3'd0, 16'd0, 5'd0, 16'd0);
    send_command(pva_pkg::FN_SETVOL, 8'hFF, 3'd0, 16'hFFFF, 5'h1F, 16'hFFFF);
    send_command(pva_pkg::FN_SETVOL, 8'd0, 3'd0, pva_pkg::UNITY, 5'd0, 16'd0);
    send_command(pva_pkg::FN_SETVOL, 8'd0, 3'd3, 16'd4096, 5'd0, 16'd0);
    send_command(pva_pkg::FN_FINISH, 8'd0, 3'd0, 16'd0, 5'd0, 16'd0);
    send_command(pva_pkg::FN_FINISH, 8'hFF, 3'd7, 16'hFFFF, 5'd0, 16'hFFFF);
    send_command(pva_pkg::FN_FINISH, 8'd0, 3'd0, 16'd0, 5'd31, 16'd0);
    send_command(pva_pkg::FN_STOPALL, 8'd0, 3'd0, 16'd0, 5'd0, 16'd0);
    send_command(pva_pkg::FN_STOPALL, 8'hFF, 3'd7, 16'hFFFF, 5'd31, 16'hFFFF);
    send_command(pva_pkg::FN_PLAY, 8'd7, 3'd1, pva_pkg::GAIN_MAX, 5'd0, 16'h0001);
    send_command(pva_pkg::FN_SETVOL, 8'd0, 3'd1, pva_pkg::GAIN_MAX, 5'd0, 16'd0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm <= (n >= 180 && n < 260);
      r = $urandom_range(99);
      if (r < 62) func = pva_pkg::FN_PLAY;
      else if (r < 76) func = pva_pkg::FN_FINISH;
      else if (r < 98) func = pva_pkg::FN_SETVOL;
      else func = pva_pkg::FN_STOPALL;
      send_command(func, pick_priority(), pva_pkg::BUS_W'($urandom), pick_volume(),
                   pva_pkg::VOICE_W'($urandom), pva_pkg::SND_W'($urandom));
    end
    in_valid <= 1'b0;
    calm     <= 1'b0;

    while (model.pending_actions.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (model.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/pva_pkg.sv
rtl/core/pva_front.sv
rtl/core/pva_cmd_fifo.sv
rtl/core/pva_engine.sv
rtl/core/priority_voice_allocator_top.sv
bench/priority_voice_allocator_top_tb.sv
